/* rtl/ols_pkg.sv */
// ----------------------------------------------------------------------------
// ols_pkg
// Shared sizes, command codes and status codes for the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

  // Storage size and derived widths
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 3;

  // Width wide enough to compare a position against count + 1
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_POS   = 3'd3,
    CMD_SEARCH    = 3'd4,
    CMD_LIST      = 3'd5
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_FOUND    = 3'd4,
    STAT_NOTFOUND = 3'd5
  } status_t;

  // Operation carried through the sequencer
  typedef enum logic [1:0] {
    OP_INS    = 2'd0,
    OP_DEL    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SH_RD  = 5'b00010,
    S_SH_WR  = 5'b00100,
    S_SC_RD  = 5'b01000,
    S_SC_CHK = 5'b10000
  } state_t;

endpackage

/* rtl/ordered_list_store.sv */
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered list of signed words with insert, delete, search and list commands.
// ----------------------------------------------------------------------------
// Error answers come straight from idle. Insert and delete move one entry at a
// time, fetching it in S_SH_RD and storing it in S_SH_WR, a split set by the
// registered memory read. Search and list fetch in S_SC_RD and check in S_SC_CHK,
// list giving one result per entry. Busy stays high until the item is done.
// Throughput: one item at a time; the next item is taken once busy falls.
// Reset clears the count, entries stay undefined until written; no output stall.
module ordered_list_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ols_pkg::CMD_W-1:0]  in_command,
  input  logic signed [ols_pkg::DATA_W-1:0] in_value,
  input  logic [ols_pkg::POS_W-1:0]  in_position,
  output logic                       out_valid,
  output logic [ols_pkg::STAT_W-1:0] out_status,
  output logic signed [ols_pkg::DATA_W-1:0] out_element,
  output logic                       out_last
);
  import ols_pkg::*;

  // List memory
  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Sequencer and item registers
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  // Result registers
  logic              ov_r, ov_nxt;
  status_t           ost_r, ost_nxt;
  logic [DATA_W-1:0] oel_r, oel_nxt;
  logic              olast_r, olast_nxt;

  // Decode helpers
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  ptr_p1;
  logic              full;
  logic              empty;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_m1  = CNT_W'(pos_ext - CMP_W'(1));
  assign ptr_p1  = CNT_W'(ptr_r + CNT_W'(1));
  assign full    = (count_r >= CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    oel_nxt   = '0;
    olast_nxt = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[ADDR_W-1:0];
    mem_wdata = rdata_r;
    mem_raddr = ptr_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt = in_value;
          case (in_command)
            CMD_INS_FRONT, CMD_INS_END: begin
              if (full) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_FULL;
              end else begin
                op_nxt    = OP_INS;
                ptr_nxt   = count_r;
                idx_nxt   = (in_command == CMD_INS_FRONT) ? '0 : count_r;
                state_nxt = S_SH_RD;
              end
            end
            CMD_INS_POS: begin
              if (empty) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_EMPTY;
              end else if (full) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_INVALID;
              end else begin
                op_nxt    = OP_INS;
                ptr_nxt   = count_r;
                idx_nxt   = pos_m1;
                state_nxt = S_SH_RD;
              end
            end
            CMD_DEL_POS: begin
              if (empty) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_INVALID;
              end else begin
                op_nxt    = OP_DEL;
                ptr_nxt   = pos_m1;
                state_nxt = S_SH_RD;
              end
            end
            CMD_SEARCH, CMD_LIST: begin
              if (empty) begin
                ov_nxt  = 1'b1;
                ost_nxt = STAT_EMPTY;
              end else begin
                op_nxt    = (in_command == CMD_SEARCH) ? OP_SEARCH : OP_LIST;
                ptr_nxt   = '0;
                state_nxt = S_SC_RD;
              end
            end
            default: begin
              ov_nxt  = 1'b1;
              ost_nxt = STAT_INVALID;
            end
          endcase
        end
      end

      // Fetch the next entry to move, or finish the item
      S_SH_RD: begin
        if (op_r == OP_INS) begin
          if (ptr_r > idx_r) begin
            mem_raddr = ADDR_W'(ptr_r - CNT_W'(1));
            state_nxt = S_SH_WR;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_r[ADDR_W-1:0];
            mem_wdata = val_r;
            count_nxt = CNT_W'(count_r + CNT_W'(1));
            ov_nxt    = 1'b1;
            ost_nxt   = STAT_OK;
            state_nxt = S_IDLE;
          end
        end else begin
          if (ptr_p1 < count_r) begin
            mem_raddr = ptr_p1[ADDR_W-1:0];
            state_nxt = S_SH_WR;
          end else begin
            count_nxt = CNT_W'(count_r - CNT_W'(1));
            ov_nxt    = 1'b1;
            ost_nxt   = STAT_OK;
            state_nxt = S_IDLE;
          end
        end
      end

      // Store the fetched entry one slot over and advance
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[ADDR_W-1:0];
        mem_wdata = rdata_r;
        ptr_nxt   = (op_r == OP_INS) ? CNT_W'(ptr_r - CNT_W'(1)) : ptr_p1;
        state_nxt = S_SH_RD;
      end

      // Fetch the entry under the scan pointer
      S_SC_RD: begin
        mem_raddr = ptr_r[ADDR_W-1:0];
        state_nxt = S_SC_CHK;
      end

      // Compare or list the fetched entry
      S_SC_CHK: begin
        if (op_r == OP_SEARCH) begin
          if (rdata_r == val_r) begin
            ov_nxt    = 1'b1;
            ost_nxt   = STAT_FOUND;
            state_nxt = S_IDLE;
          end else if (ptr_p1 == count_r) begin
            ov_nxt    = 1'b1;
            ost_nxt   = STAT_NOTFOUND;
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_p1;
            state_nxt = S_SC_RD;
          end
        end else begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_OK;
          oel_nxt   = rdata_r;
          olast_nxt = (ptr_p1 == count_r);
          ptr_nxt   = ptr_p1;
          state_nxt = (ptr_p1 == count_r) ? S_IDLE : S_SC_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ptr_r   <= ptr_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    ost_r   <= ost_nxt;
    oel_r   <= oel_nxt;
    olast_r <= olast_nxt;
  end

  // List memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_r[mem_raddr];
  end

  // Drive ports
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = ov_r;
  assign out_status  = ost_r;
  assign out_element = oel_r;
  assign out_last    = olast_r;

endmodule
